// File: src/lrs_pkg.sv
package lrs_pkg;

  localparam int MAX_FEATURES_DEF = 256;
  localparam int SIG_DEPTH_DEF    = 1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic [15:0]        PROB_MAX  = 16'hFFFF;
  localparam logic [15:0]        PROB_MIN  = 16'h0000;

  typedef enum logic {
    MODE_WEIGHT  = 1'b0,
    MODE_FEATURE = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_FEATURE_COUNT = 1'b0,
    CFG_BIAS          = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] weight;
    logic signed [15:0] value;
    logic               last;
  } work_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [15:0]        probability;
  } result_t;

endpackage

// File: src/lrs_fifo.sv
module lrs_fifo #(
  parameter int DEPTH = lrs_pkg::QUEUE_DEPTH,
  parameter int W     = $bits(lrs_pkg::work_t)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign do_push = push;
  assign do_pop  = pop && (count_r != '0);
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CW'(DEPTH))
    else $error("request pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("request count beyond queue depth");

endmodule

// File: src/lrs_sigmoid.sv
module lrs_sigmoid #(
  parameter int SIGMOID_TABLE_DEPTH = lrs_pkg::SIG_DEPTH_DEF
) (
  input  logic                                                   clk,
  input  logic [((SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1)-1:0] idx,
  output logic [15:0]                                            entry
);

  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] HALF30 = 64'd1 << 29;

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [15:0] sig_entry(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] p;
    y  = x >> 2;
    t2 = ((y * y) >> 30) >> 1;
    t3 = udiv((t2 * y) >> 30, 64'd3);
    t4 = ((t3 * y) >> 30) >> 2;
    e  = ONE30 - y + t2 - t3 + t4;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + HALF30) >> 30;
    end
    d = ONE30 + e;
    p = udiv((64'd1 << 46) + (d >> 1), d);
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  logic [15:0] rom [SIGMOID_TABLE_DEPTH];
  logic [15:0] entry_r;

  for (genvar gi = 0; gi < SIGMOID_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] XQ = (64'(gi) << 27) / 64'(SIGMOID_TABLE_DEPTH);
    localparam logic [15:0] ENTRY_VAL = sig_entry(XQ);
    assign rom[gi] = ENTRY_VAL;
  end

  always_ff @(posedge clk) begin
    entry_r <= rom[idx];
  end

  assign entry = entry_r;

endmodule

// File: src/lrs_front.sv
module lrs_front #(
  parameter int MAX_FEATURES = lrs_pkg::MAX_FEATURES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_mode,
  input  logic [7:0]                 in_weight_index,
  input  logic signed [15:0]         in_value,
  input  logic [8:0]                 feature_count,
  input  logic [lrs_pkg::QCNT_W-1:0] q_count,
  output logic                       work_valid,
  output lrs_pkg::work_t             work
);

  localparam int AW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW  = (($clog2(MAX_FEATURES + 1) > 9) ? $clog2(MAX_FEATURES + 1) : 9) + 1;
  localparam int QCW = lrs_pkg::QCNT_W;

  logic signed [15:0] weight_store_r [MAX_FEATURES];
  logic signed [15:0] weight_rd_r;
  logic signed [15:0] value_r;
  logic               last_r;
  logic               valid_r;
  logic [AW-1:0]      pos_r, pos_nxt;

  logic               accept;
  logic               is_feat;
  logic               take_feat;
  logic               wr_en;
  logic               last;
  logic [AW+7:0]      widx_ext;
  logic [CW-1:0]      cnt_raw;
  logic [CW-1:0]      cnt_eff;
  logic [CW-1:0]      pos_inc;
  logic [QCW:0]       occupancy;

  assign occupancy = {1'b0, q_count} + (QCW + 1)'(valid_r);
  assign full      = occupancy >= (QCW + 1)'(lrs_pkg::QUEUE_DEPTH);
  assign accept    = push && !full;
  assign is_feat   = lrs_pkg::mode_t'(in_mode) == lrs_pkg::MODE_FEATURE;
  assign take_feat = accept && is_feat;
  assign widx_ext  = {{AW{1'b0}}, in_weight_index};
  assign wr_en     = accept && !is_feat && (widx_ext < (AW + 8)'(MAX_FEATURES));

  always_comb begin
    cnt_raw = CW'(feature_count);
    if (cnt_raw == '0) begin
      cnt_eff = CW'(1);
    end else if (cnt_raw > CW'(MAX_FEATURES)) begin
      cnt_eff = CW'(MAX_FEATURES);
    end else begin
      cnt_eff = cnt_raw;
    end
    pos_inc = CW'(pos_r) + CW'(1);
    last    = pos_inc >= cnt_eff;
    pos_nxt = last ? '0 : pos_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_store_r[widx_ext[AW-1:0]] <= in_value;
    end
    if (take_feat) begin
      weight_rd_r <= weight_store_r[pos_r];
      value_r     <= in_value;
      last_r      <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= take_feat;
      if (take_feat) begin
        pos_r <= pos_nxt;
      end
    end
  end

  assign work_valid   = valid_r;
  assign work.weight  = weight_rd_r;
  assign work.value   = value_r;
  assign work.last    = last_r;

  a_pos_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (take_feat && last) |=> pos_r == '0)
    else $error("feature position not cleared after last feature");

endmodule

// File: src/lrs_back.sv
module lrs_back #(
  parameter int MAX_FEATURES        = lrs_pkg::MAX_FEATURES_DEF,
  parameter int SIGMOID_TABLE_DEPTH = lrs_pkg::SIG_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [31:0]         bias,
  input  logic                       q_empty,
  input  lrs_pkg::work_t             q_data,
  output logic                       q_pop,
  input  logic [lrs_pkg::OCNT_W-1:0] out_count,
  output logic                       res_push,
  output lrs_pkg::result_t           res
);

  localparam int ACC_W = 32 + ((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1);
  localparam int IW    = (SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1;
  localparam int DW    = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int SUMW  = lrs_pkg::OCNT_W + 2;

  logic                      v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                      last1_r;
  logic signed [31:0]        prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   tot_r;
  logic signed [31:0]        score3_r, score4_r, score5_r;
  logic                      neg4_r, neg5_r;
  logic                      big4_r, big5_r;
  logic [IW-1:0]             idx4_r;

  logic signed [15:0]        w_in, v_in;
  logic signed [31:0]        prod_nxt;
  logic signed [ACC_W-1:0]   sum2;
  logic signed [ACC_W:0]     wide3;
  logic [ACC_W-31:0]         top3;
  logic signed [31:0]        score_nxt;
  logic                      neg_nxt;
  logic [31:0]               mag;
  logic [27+DW-1:0]          scaled;
  logic [15:0]               rom_q;
  logic [16:0]               mirrored;
  logic [2:0]                inflight;
  logic [SUMW-1:0]           credit;

  assign inflight = 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r) + 3'(v5_r);
  assign credit   = SUMW'(out_count) + SUMW'(inflight);
  assign q_pop    = !q_empty && (credit < SUMW'(lrs_pkg::OUT_DEPTH));

  assign w_in     = q_data.weight;
  assign v_in     = q_data.value;
  assign prod_nxt = w_in * v_in;
  assign sum2     = acc_r + ACC_W'(prod_r);

  always_comb begin
    wide3 = (ACC_W + 1)'(tot_r) + (ACC_W + 1)'(bias);
    top3  = wide3[ACC_W:31];
    if ((&top3) || !(|top3)) begin
      score_nxt = wide3[31:0];
    end else if (wide3[ACC_W]) begin
      score_nxt = lrs_pkg::SCORE_MIN;
    end else begin
      score_nxt = lrs_pkg::SCORE_MAX;
    end
  end

  assign neg_nxt = score3_r[31];
  assign mag     = neg_nxt ? 32'(-score3_r) : 32'(score3_r);
  assign scaled  = (27 + DW)'(mag[26:0]) * (27 + DW)'(SIGMOID_TABLE_DEPTH);

  lrs_sigmoid #(
    .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
  ) u_sigmoid (
    .clk   (clk),
    .idx   (idx4_r),
    .entry (rom_q)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r  <= prod_nxt;
      last1_r <= q_data.last;
    end
    if (v1_r) begin
      tot_r <= sum2;
    end
    score3_r <= score_nxt;
    score4_r <= score3_r;
    neg4_r   <= neg_nxt;
    big4_r   <= |mag[31:27];
    idx4_r   <= scaled[27 +: IW];
    score5_r <= score4_r;
    neg5_r   <= neg4_r;
    big5_r   <= big4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r <= q_pop;
      v2_r <= v1_r && last1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (v1_r) begin
        acc_r <= last1_r ? '0 : sum2;
      end
    end
  end

  assign mirrored = 17'h10000 - 17'(rom_q);

  always_comb begin
    res.score = score5_r;
    if (big5_r) begin
      res.probability = neg5_r ? lrs_pkg::PROB_MIN : lrs_pkg::PROB_MAX;
    end else begin
      res.probability = neg5_r ? mirrored[15:0] : rom_q;
    end
  end

  assign res_push = v5_r;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit <= SUMW'(lrs_pkg::OUT_DEPTH))
    else $error("results in flight exceed result queue space");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> acc_r == '0)
    else $error("accumulator not cleared after last feature");

endmodule

// File: src/logistic_regression_scorer.sv
// Path: the last feature of a data point passes the front register, the work queue,
//   the product, total, score, index and result registers, then the result queue.
// Throughput: one request per cycle, weight or feature, while full is low; the weight
//   store read and the multiply-accumulate are pipelined and the result queue holds 8.
// Reset: rst_n (synchronous) clears queues, position and accumulator and sets
//   feature_count to 1 and bias to 0; the weight store is not cleared.
module logistic_regression_scorer #(
  parameter int MAX_FEATURES        = lrs_pkg::MAX_FEATURES_DEF,
  parameter int SIGMOID_TABLE_DEPTH = lrs_pkg::SIG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_mode,
  input  logic [7:0]         in_weight_index,
  input  logic signed [15:0] in_value,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_score,
  output logic [15:0]        out_probability,
  input  logic               valid,
  output logic               ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int WORK_W = $bits(lrs_pkg::work_t);
  localparam int RES_W  = $bits(lrs_pkg::result_t);

  logic [8:0]                 feature_count_r;
  logic signed [31:0]         bias_r;

  logic                       work_valid;
  lrs_pkg::work_t             work_in;
  lrs_pkg::work_t             work_out;
  logic [WORK_W-1:0]          work_in_bits;
  logic [WORK_W-1:0]          work_out_bits;
  logic                       q_pop;
  logic                       q_empty;
  logic [lrs_pkg::QCNT_W-1:0] q_count;

  logic                       res_push;
  lrs_pkg::result_t           res_in;
  lrs_pkg::result_t           res_out;
  logic [RES_W-1:0]           res_out_bits;
  logic [lrs_pkg::OCNT_W-1:0] out_count;

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_count_r <= 9'd1;
      bias_r          <= '0;
    end else if (valid && ready) begin
      unique case (lrs_pkg::cfg_reg_t'(cfg_index))
        lrs_pkg::CFG_FEATURE_COUNT: feature_count_r <= cfg_data[8:0];
        lrs_pkg::CFG_BIAS:          bias_r          <= cfg_data;
      endcase
    end
  end

  lrs_front #(
    .MAX_FEATURES(MAX_FEATURES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_weight_index (in_weight_index),
    .in_value        (in_value),
    .feature_count   (feature_count_r),
    .q_count         (q_count),
    .work_valid      (work_valid),
    .work            (work_in)
  );

  assign work_in_bits = work_in;
  assign work_out     = work_out_bits;

  lrs_fifo #(
    .DEPTH (lrs_pkg::QUEUE_DEPTH),
    .W     (WORK_W)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (work_valid),
    .wdata (work_in_bits),
    .pop   (q_pop),
    .rdata (work_out_bits),
    .empty (q_empty),
    .count (q_count)
  );

  lrs_back #(
    .MAX_FEATURES        (MAX_FEATURES),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bias      (bias_r),
    .q_empty   (q_empty),
    .q_data    (work_out),
    .q_pop     (q_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  lrs_fifo #(
    .DEPTH (lrs_pkg::OUT_DEPTH),
    .W     (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out_bits),
    .empty (empty),
    .count (out_count)
  );

  assign res_out         = res_out_bits;
  assign out_score       = res_out.score;
  assign out_probability = res_out.probability;

endmodule

// File: sim/testbench.sv
module testbench;

  localparam int            ITEM_TARGET  = 1900;
  localparam int            DRAIN_CYCLES = 16;
  localparam bit [63:0]     Q30_ONE      = 64'd1 << 30;
  localparam bit [63:0]     RANGE_Q824   = 64'd1 << 27;

  logic               clk;
  logic               rst_n           = 1'b0;
  logic               push            = 1'b0;
  logic               full;
  logic               in_mode         = lrs_pkg::MODE_WEIGHT;
  logic [7:0]         in_weight_index = 8'd0;
  logic signed [15:0] in_value        = 16'sd0;
  logic               empty;
  logic               pop             = 1'b0;
  logic signed [31:0] out_score;
  logic [15:0]        out_probability;
  logic               valid           = 1'b0;
  logic               ready;
  logic [0:0]         cfg_index       = lrs_pkg::CFG_FEATURE_COUNT;
  logic [31:0]        cfg_data        = 32'd0;

  // scorer state as the testbench sees it
  logic signed [15:0] weights [lrs_pkg::MAX_FEATURES_DEF];
  logic [15:0]        sigmoid_lut [lrs_pkg::SIG_DEPTH_DEF];
  longint             dot_acc     = 0;
  int unsigned        point_pos   = 0;
  logic [8:0]         count_reg   = 9'd1;
  logic signed [31:0] bias_reg    = 32'sd0;

  lrs_pkg::result_t   expected_scores [$];
  int                 mismatches      = 0;
  int                 results_checked = 0;
  int                 items_sent      = 0;
  int                 hold_cycles     = 0;
  bit                 burst_mode      = 1'b0;

  logistic_regression_scorer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_weight_index (in_weight_index),
    .in_value        (in_value),
    .empty           (empty),
    .pop             (pop),
    .out_score       (out_score),
    .out_probability (out_probability),
    .valid           (valid),
    .ready           (ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] sigmoid_point(bit [63:0] x);
    bit [63:0] y, t2, t3, t4, e, d, p;
    y  = x >> 2;
    t2 = ((y * y) >> 30) / 2;
    t3 = ((t2 * y) >> 30) / 3;
    t4 = ((t3 * y) >> 30) / 4;
    e  = Q30_ONE - y + t2 - t3 + t4;
    repeat (8) e = (e * e + (64'd1 << 29)) >> 30;
    d = Q30_ONE + e;
    p = ((64'd1 << 46) + d / 2) / d;
    return (p > 64'd65535) ? lrs_pkg::PROB_MAX : p[15:0];
  endfunction

  function automatic logic [15:0] probability_of(logic signed [31:0] s);
    bit [63:0] mag;
    bit [63:0] idx;
    if (s < 0) mag = -longint'(s);
    else mag = longint'(s);
    if (mag >= RANGE_Q824) return (s < 0) ? lrs_pkg::PROB_MIN : lrs_pkg::PROB_MAX;
    idx = (mag * lrs_pkg::SIG_DEPTH_DEF) >> 27;
    if (idx >= lrs_pkg::SIG_DEPTH_DEF) idx = lrs_pkg::SIG_DEPTH_DEF - 1;
    if (s >= 0) return sigmoid_lut[idx];
    return 16'(32'd65536 - sigmoid_lut[idx]);
  endfunction

  function automatic void score_request(lrs_pkg::mode_t m, logic [7:0] idx,
                                        logic signed [15:0] v);
    int unsigned      span;
    int unsigned      pos;
    longint           total;
    lrs_pkg::result_t r;
    if (m == lrs_pkg::MODE_WEIGHT) begin
      weights[idx] = v;
      return;
    end
    span = count_reg;
    if (span == 0) span = 1;
    if (span > lrs_pkg::MAX_FEATURES_DEF) span = lrs_pkg::MAX_FEATURES_DEF;
    pos = point_pos;
    if (pos >= lrs_pkg::MAX_FEATURES_DEF) pos = lrs_pkg::MAX_FEATURES_DEF - 1;
    dot_acc += longint'(weights[pos]) * longint'(v);
    if (pos + 1 < span) begin
      point_pos = pos + 1;
      return;
    end
    total = dot_acc + longint'(bias_reg);
    if (total > longint'(lrs_pkg::SCORE_MAX)) r.score = lrs_pkg::SCORE_MAX;
    else if (total < longint'(lrs_pkg::SCORE_MIN)) r.score = lrs_pkg::SCORE_MIN;
    else r.score = 32'(total);
    r.probability = probability_of(r.score);
    expected_scores.push_back(r);
    dot_acc   = 0;
    point_pos = 0;
  endfunction

  task automatic report_error(string msg);
    mismatches++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic send_item(lrs_pkg::mode_t m, logic [7:0] idx, logic signed [15:0] v);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    in_mode         <= m;
    in_weight_index <= idx;
    in_value        <= v;
    do @(posedge clk); while (full);
    items_sent++;
    score_request(m, idx, v);
  endtask

  task automatic wait_quiet();
    push <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lrs_pkg::cfg_reg_t r, logic [31:0] d);
    wait_quiet();
    valid     <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!ready);
    valid <= 1'b0;
    if (r == lrs_pkg::CFG_FEATURE_COUNT) count_reg = d[8:0];
    else bias_reg = d;
  endtask

  // results side: check every popped result, stall at random
  initial begin : result_side
    int               stall;
    lrs_pkg::result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        results_checked++;
        if (expected_scores.size() == 0) begin
          report_error($sformatf("unexpected result score %0d probability %0d",
                                 out_score, out_probability));
        end else begin
          want = expected_scores.pop_front();
          if (out_score !== want.score)
            report_error($sformatf("score got %0d expected %0d", out_score, want.score));
          if (out_probability !== want.probability)
            report_error($sformatf("probability got %0d expected %0d (score %0d)",
                                   out_probability, want.probability, want.score));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop   <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  function automatic logic signed [15:0] weight_value();
    if ($urandom_range(0, 99) < 70) return 16'($signed($urandom_range(0, 4096)) - 2048);
    return 16'($urandom());
  endfunction

  function automatic logic signed [15:0] feature_value();
    if ($urandom_range(0, 99) < 70) return 16'($signed($urandom_range(0, 8192)) - 4096);
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 16);
    if (r < 93) return $urandom_range(17, 64);
    if (r < 96) return 256;
    if (r < 98) return 0;
    return $urandom_range(257, 511);
  endfunction

  function automatic logic [31:0] pick_bias();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    if (r < 85) return $urandom();
    if (r < 90) return lrs_pkg::SCORE_MAX;
    if (r < 95) return lrs_pkg::SCORE_MIN;
    return 32'd0;
  endfunction

  task automatic load_weights();
    int i;
    for (i = 0; i < lrs_pkg::MAX_FEATURES_DEF; i++)
      send_item(lrs_pkg::MODE_WEIGHT, 8'(i), weight_value());
  endtask

  task automatic test_single_feature();
    send_item(lrs_pkg::MODE_WEIGHT, 8'd0, 16'sh7FFF);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sh7FFF);
    send_item(lrs_pkg::MODE_FEATURE, 8'hFF, -16'sh8000);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sd0);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sd1);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, -16'sd1);
    send_item(lrs_pkg::MODE_WEIGHT, 8'd0, -16'sh8000);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, -16'sh8000);
    send_item(lrs_pkg::MODE_WEIGHT, 8'd0, 16'sd4096);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sd4096);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, -16'sd2048);
  endtask

  task automatic test_bias_extremes();
    write_reg(lrs_pkg::CFG_BIAS, lrs_pkg::SCORE_MAX);
    send_item(lrs_pkg::MODE_WEIGHT, 8'd0, 16'sh7FFF);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sh7FFF);
    write_reg(lrs_pkg::CFG_BIAS, lrs_pkg::SCORE_MIN);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, -16'sh8000);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sd0);
    write_reg(lrs_pkg::CFG_BIAS, 32'd0);
  endtask

  task automatic test_count_special();
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd0);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sd1234);
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd2);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, 16'sd4096);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, -16'sd4096);
  endtask

  task automatic test_count_change_mid_point();
    int k;
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd6);
    for (k = 0; k < 4; k++) send_item(lrs_pkg::MODE_FEATURE, 8'd0, feature_value());
    // shrink below the current position: next feature closes the point
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd2);
    send_item(lrs_pkg::MODE_FEATURE, 8'd0, feature_value());
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd3);
    for (k = 0; k < 2; k++) send_item(lrs_pkg::MODE_FEATURE, 8'd0, feature_value());
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd6);
    for (k = 0; k < 4; k++) send_item(lrs_pkg::MODE_FEATURE, 8'd0, feature_value());
  endtask

  task automatic test_long_points();
    int k;
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd511);
    for (k = 0; k < lrs_pkg::MAX_FEATURES_DEF; k++)
      send_item(lrs_pkg::MODE_FEATURE, 8'($urandom()), 16'($urandom()));
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd256);
    for (k = 0; k < lrs_pkg::MAX_FEATURES_DEF; k++)
      send_item(lrs_pkg::MODE_FEATURE, 8'd0, -16'sh8000);
  endtask

  task automatic test_back_pressure();
    int k;
    write_reg(lrs_pkg::CFG_FEATURE_COUNT, 32'd1);
    write_reg(lrs_pkg::CFG_BIAS, pick_bias());
    hold_cycles = 400;
    burst_mode  = 1'b1;
    for (k = 0; k < 48; k++) send_item(lrs_pkg::MODE_FEATURE, 8'd0, feature_value());
    burst_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase_len;
    int k;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) write_reg(lrs_pkg::CFG_FEATURE_COUNT, pick_count());
      if ($urandom_range(0, 2) == 0) write_reg(lrs_pkg::CFG_BIAS, pick_bias());
      burst_mode = ($urandom_range(0, 5) == 0);
      phase_len  = $urandom_range(40, 120);
      for (k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < 12)
          send_item(lrs_pkg::MODE_WEIGHT, 8'($urandom_range(0, 255)), weight_value());
        else
          send_item(lrs_pkg::MODE_FEATURE, 8'($urandom()), feature_value());
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < lrs_pkg::SIG_DEPTH_DEF; i++)
      sigmoid_lut[i] = sigmoid_point((64'(i) * RANGE_Q824) / lrs_pkg::SIG_DEPTH_DEF);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_weights();
    test_single_feature();
    test_bias_extremes();
    test_count_special();
    test_count_change_mid_point();
    test_long_points();
    test_back_pressure();
    test_random_traffic();
    wait_quiet();

    $display("run covered %0d requests and %0d checked results", items_sent, results_checked);
    $display("feature counts 0 to 511, bias and score saturation, input stall under hold");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 1500000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
